// ===== rtl/core/dmd_pkg.sv =====
package dmd_pkg;

    // Fixed field widths of the stream and configuration port.
    localparam int DEPTH_W        = 24;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;

    // Defaults handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 24;

    // Frame geometry limits and reset values.
    localparam int WIDTH_MIN      = 3;
    localparam int WIDTH_RST      = 640;
    localparam int HEIGHT_MIN     = 2;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int HEIGHT_RST     = 480;
    localparam int ROW_W          = $clog2(HEIGHT_LIMIT + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [DEPTH_W-1:0]   depth_in;
    } t_in_item;

    typedef struct packed {
        logic [DEPTH_W-1:0]   depth_out;
        logic                 frame_last;
    } t_out_item;

    // Control word of one item between the front end and the vertical stage.
    typedef struct packed {
        logic emit;        // item produces a result
        logic wr;          // item updates the line buffer column
        logic at_edge;     // first or last column: pass through
        logic use_older;   // include the older row in the vertical max
        logic frame_last;  // result is the final pixel of the frame
    } t_cmd_ctl;

endpackage

// ===== rtl/core/dmd_line_buf.sv =====
module dmd_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dmd_front.sv =====
module dmd_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  dmd_pkg::t_in_item                i_in_item,
    input  logic                             i_take,
    output logic                             o_cmd_valid,
    output dmd_pkg::t_cmd_ctl                o_cmd,
    output logic [PIXEL_BITS-1:0]            o_cmd_v,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_cmd_addr,
    output logic                             o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_rd_addr
);

    import dmd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMPW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [CW-1:0]         r_width;
    logic [ROW_W-1:0]      r_height;
    logic [ROW_W-1:0]      r_in_row;
    logic [CW-1:0]         r_in_col;
    logic [PIXEL_BITS-1:0] r_left;
    logic [PIXEL_BITS-1:0] r_center;
    logic                  r_cmd_valid;
    t_cmd_ctl              r_cmd;
    logic [PIXEL_BITS-1:0] r_cmd_v;
    logic [AW-1:0]         r_cmd_addr;

    logic [CMPW-1:0]       raw_w;
    logic [CFG_W-1:0]      raw_h;
    logic [CW-1:0]         n_width;
    logic [ROW_W-1:0]      n_height;
    t_cmd_ctl              n_cmd;
    logic [PIXEL_BITS-1:0] n_cmd_v;

    logic                  s1_ready;
    logic                  accept;
    logic                  is_flush;
    logic                  draining;
    logic                  col_nz;
    logic                  first_px;
    logic [CW-1:0]         w_last;
    logic [CW-1:0]         pc;
    logic                  at_edge;
    logic                  row_ge1;
    logic                  row_eq1;
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] cur;
    logic [PIXEL_BITS-1:0] m_lc;
    logic [PIXEL_BITS-1:0] m_lcr;
    logic [PIXEL_BITS-1:0] hmax;

    // Saturate register writes into the supported geometry.
    always_comb begin
        raw_w = CMPW'(i_cfg_data);
        raw_h = i_cfg_data;
        if (raw_w < CMPW'(WIDTH_MIN)) begin
            n_width = CW'(WIDTH_MIN);
        end else if (raw_w > CMPW'(MAX_WIDTH)) begin
            n_width = CW'(MAX_WIDTH);
        end else begin
            n_width = raw_w[CW-1:0];
        end
        if (raw_h < CFG_W'(HEIGHT_MIN)) begin
            n_height = ROW_W'(HEIGHT_MIN);
        end else if (raw_h > CFG_W'(HEIGHT_LIMIT)) begin
            n_height = ROW_W'(HEIGHT_LIMIT);
        end else begin
            n_height = ROW_W'(raw_h);
        end
    end

    assign s1_ready = !r_cmd_valid || i_take;
    assign accept   = i_in_valid && s1_ready;
    assign is_flush = (i_in_item.action == ACT_FLUSH);
    assign draining = (r_in_row >= r_height);
    assign col_nz   = (r_in_col != '0);
    assign first_px = (r_in_row == '0) && !col_nz;
    assign w_last   = r_width - CW'(1);
    // The column finished by this item; wraps to the last column at a row start.
    assign pc       = col_nz ? (r_in_col - CW'(1)) : w_last;
    assign at_edge  = (pc == '0) || (pc == w_last);
    assign row_ge1  = col_nz ? (r_in_row >= ROW_W'(1)) : (r_in_row >= ROW_W'(2));
    assign row_eq1  = col_nz ? (r_in_row == ROW_W'(1)) : (r_in_row == ROW_W'(2));

    // Horizontal max over left, center and the new pixel.
    assign px    = PIXEL_BITS'(i_in_item.depth_in);
    assign cur   = is_flush ? '0 : px;
    assign m_lc  = (r_left > r_center) ? r_left : r_center;
    assign m_lcr = (m_lc > cur) ? m_lc : cur;
    assign hmax  = at_edge ? r_center : m_lcr;

    always_comb begin
        n_cmd   = '0;
        n_cmd_v = hmax;
        if (!is_flush && !draining) begin
            n_cmd.emit      = !first_px && row_ge1;
            n_cmd.wr        = !first_px;
            n_cmd.at_edge   = at_edge;
            n_cmd.use_older = !row_eq1;
        end else if (is_flush && draining) begin
            n_cmd.emit       = 1'b1;
            n_cmd.wr         = !col_nz;
            n_cmd.at_edge    = at_edge;
            n_cmd.use_older  = 1'b1;
            n_cmd.frame_last = (r_in_col == r_width);
            if (col_nz) begin
                n_cmd_v = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(W_RST);
            r_height <= ROW_W'(HEIGHT_RST);
            r_in_row <= '0;
            r_in_col <= '0;
            r_left   <= '0;
            r_center <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_WIDTH: begin
                    r_width  <= n_width;
                    r_in_row <= '0;
                    r_in_col <= '0;
                    r_left   <= '0;
                    r_center <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= n_height;
                    r_in_row <= '0;
                    r_in_col <= '0;
                    r_left   <= '0;
                    r_center <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (!is_flush && !draining) begin
                r_left   <= r_center;
                r_center <= px;
                if (r_in_col == w_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end else if (is_flush && draining) begin
                if (r_in_col >= r_width) begin
                    r_in_row <= '0;
                    r_in_col <= '0;
                    r_left   <= '0;
                    r_center <= '0;
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (s1_ready) begin
            r_cmd_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_cmd      <= n_cmd;
            r_cmd_v    <= n_cmd_v;
            r_cmd_addr <= pc[AW-1:0];
        end
    end

    assign o_in_ready  = s1_ready;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;
    assign o_cmd_v     = r_cmd_v;
    assign o_cmd_addr  = r_cmd_addr;
    assign o_rd_en     = s1_ready;
    assign o_rd_addr   = pc[AW-1:0];

endmodule

// ===== rtl/core/dmd_back.sv =====
module dmd_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  dmd_pkg::t_cmd_ctl              i_cmd,
    input  logic [PIXEL_BITS-1:0]          i_cmd_v,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_cmd_addr,
    input  logic [2*PIXEL_BITS-1:0]        i_rd_data,
    output logic                           o_take,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_wr_addr,
    output logic [2*PIXEL_BITS-1:0]        o_wr_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dmd_pkg::t_out_item             o_out_item
);

    import dmd_pkg::*;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  take;
    logic [PIXEL_BITS-1:0] older;
    logic [PIXEL_BITS-1:0] recent;
    logic [PIXEL_BITS-1:0] older_m;
    logic [PIXEL_BITS-1:0] m_or;
    logic [PIXEL_BITS-1:0] m_orv;
    logic [PIXEL_BITS-1:0] res;

    assign take    = !r_out_valid || i_out_ready;
    assign older   = i_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign recent  = i_rd_data[PIXEL_BITS-1:0];

    // Vertical max across the older row, recent row and this row.
    assign older_m = i_cmd.use_older ? older : '0;
    assign m_or    = (older_m > recent) ? older_m : recent;
    assign m_orv   = (m_or > i_cmd_v) ? m_or : i_cmd_v;
    assign res     = i_cmd.at_edge ? recent : m_orv;

    // Shift the column: recent becomes older, this row becomes recent.
    assign o_wr_en   = i_cmd_valid && i_cmd.wr && take;
    assign o_wr_addr = i_cmd_addr;
    assign o_wr_data = {recent, i_cmd_v};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= i_cmd_valid && i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cmd_valid && i_cmd.emit) begin
            r_out_item.depth_out  <= DEPTH_W'(res);
            r_out_item.frame_last <= i_cmd.frame_last;
        end
    end

    assign o_take      = take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/depth_map_dilation_3x3.sv =====
// 3x3 max (dilation) filter over a raster stream of depth pixels. Pixels and
// flush ticks enter on the input channel at up to one transfer per clock; a
// result is registered in the stage and output registers after its transfer.
// In stream terms a result lags its pixel by one row plus one pixel, so after
// the last pixel of a frame send frame_width+1 flush ticks to drain it;
// frame_last marks the final result. Pixels arriving while draining, and
// flushes arriving mid-frame, are dropped without a result. The first and
// last columns pass through unchanged, and the top and bottom rows use only
// the rows that exist. Both line buffers share one memory word per column,
// read once and written once per clock, and that port pair sets the one item
// per clock rate unless the output stalls. The line memory needs no clearing
// pass after reset: every entry is written in a frame before it is read.
// Write frame_width or frame_height only while idle; a write restarts the
// frame, and values outside 3..MAX_WIDTH and 2..1024 saturate.
module depth_map_dilation_3x3 #(
    parameter int MAX_WIDTH  = dmd_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = dmd_pkg::PIXEL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dmd_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dmd_pkg::t_out_item             o_out_item
);

    import dmd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = 2 * PIXEL_BITS;

    // Stage register between the front end and the vertical max.
    logic                  cmd_valid;
    t_cmd_ctl              cmd;
    logic [PIXEL_BITS-1:0] cmd_v;
    logic [AW-1:0]         cmd_addr;
    logic                  take;

    // Line memory: {older row, recent row} horizontal maxima per column.
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;

    // Counters, horizontal max and per-item decode; hold while the stage stalls.
    dmd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_take      (take),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_cmd_v     (cmd_v),
        .o_cmd_addr  (cmd_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    dmd_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (DW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Vertical max, line memory update and the output register.
    dmd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_cmd_v     (cmd_v),
        .i_cmd_addr  (cmd_addr),
        .i_rd_data   (rd_data),
        .o_take      (take),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/core/dmd_checker.sv =====
module dmd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  dmd_pkg::t_out_item  o_out_item
);

    // A stalled result holds until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    // Input back-pressure only comes from a result that is waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with no waiting result");

    // A new result only follows an input transfer, through the stage register and the output register.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a matching input transfer");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind depth_map_dilation_3x3 dmd_checker u_dmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
